// ----- hw/rtl/cmvd_pkg.sv -----
// ----------------------------------------------------------------------------
// cmvd_pkg
// shared types and constants for the chunk metadata varint delta decoder
// ----------------------------------------------------------------------------
package cmvd_pkg;

  localparam int MAX_VARINT_BYTES = 10;
  localparam int VB_W             = 4;
  localparam int WORD_W           = 64;

  typedef enum logic [2:0] {
    PH_LEN   = 3'd0,
    PH_COUNT = 3'd1,
    PH_TIME  = 3'd2,
    PH_SPAN  = 3'd3,
    PH_REF   = 3'd4,
    PH_IDLE  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_META  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  typedef struct packed {
    status_t                   status;
    logic [WORD_W-1:0]         chunk_ref;
    logic signed [WORD_W-1:0]  min_time;
    logic signed [WORD_W-1:0]  max_time;
    logic                      last_chunk;
  } result_t;

endpackage

// ----- hw/rtl/cmvd_in_reg.sv -----
// ----------------------------------------------------------------------------
// cmvd_in_reg
// input register: holds one byte word until the parser can take it
// ----------------------------------------------------------------------------
module cmvd_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] data_byte,
  input  logic       entry_start,
  input  logic       down_ready,
  output logic       in_stall,
  output logic       held_valid,
  output logic [7:0] held_byte,
  output logic       held_start
);

  // stall only while a held word cannot move on
  assign in_stall = held_valid & ~down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      held_byte  <= data_byte;
      held_start <= entry_start;
    end
  end

endmodule

// ----- hw/rtl/cmvd_parser.sv -----
// ----------------------------------------------------------------------------
// cmvd_parser
// varint accumulator, entry state and delta sums; one byte per fire
// ----------------------------------------------------------------------------
module cmvd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        data_byte,
  input  logic              entry_start,
  output logic              res_valid,
  output cmvd_pkg::result_t res
);
  import cmvd_pkg::*;

  phase_t             phase, phase_next;
  logic [WORD_W-1:0]  varint_accum, varint_accum_next;
  logic [VB_W-1:0]    varint_bytes, varint_bytes_next;
  logic [WORD_W-1:0]  bytes_left, bytes_left_next;
  logic [WORD_W-1:0]  chunks_left, chunks_left_next;
  logic [WORD_W-1:0]  prev_time, prev_time_next;
  logic [WORD_W-1:0]  prev_max, prev_max_next;
  logic [WORD_W-1:0]  prev_ref, prev_ref_next;
  logic               is_first_chunk, is_first_chunk_next;

  phase_t             e_phase;
  logic [WORD_W-1:0]  e_accum;
  logic [VB_W-1:0]    e_vb;
  logic [WORD_W-1:0]  e_left;
  logic [WORD_W-1:0]  e_chunks;
  logic [WORD_W-1:0]  e_time;
  logic [WORD_W-1:0]  e_max;
  logic [WORD_W-1:0]  e_ref;
  logic               e_first;
  logic [6:0]         shamt;
  logic [WORD_W-1:0]  acc_or;
  logic [VB_W-1:0]    vb_inc;
  logic               fail;
  logic [WORD_W-1:0]  ref_new;

  function automatic logic [WORD_W-1:0] unzigzag(input logic [WORD_W-1:0] u);
    unzigzag = (u >> 1) ^ {WORD_W{u[0]}};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_LEN;
      varint_accum   <= '0;
      varint_bytes   <= '0;
      bytes_left     <= '0;
      chunks_left    <= '0;
      prev_time      <= '0;
      prev_max       <= '0;
      prev_ref       <= '0;
      is_first_chunk <= 1'b1;
    end else begin
      phase          <= phase_next;
      varint_accum   <= varint_accum_next;
      varint_bytes   <= varint_bytes_next;
      bytes_left     <= bytes_left_next;
      chunks_left    <= chunks_left_next;
      prev_time      <= prev_time_next;
      prev_max       <= prev_max_next;
      prev_ref       <= prev_ref_next;
      is_first_chunk <= is_first_chunk_next;
    end
  end

  always_comb begin
    // a start byte sees a freshly cleared entry
    if (entry_start) begin
      e_phase  = PH_LEN;
      e_accum  = '0;
      e_vb     = '0;
      e_left   = '0;
      e_chunks = '0;
      e_time   = '0;
      e_max    = '0;
      e_ref    = '0;
      e_first  = 1'b1;
    end else begin
      e_phase  = phase;
      e_accum  = varint_accum;
      e_vb     = varint_bytes;
      e_left   = bytes_left;
      e_chunks = chunks_left;
      e_time   = prev_time;
      e_max    = prev_max;
      e_ref    = prev_ref;
      e_first  = is_first_chunk;
    end

    shamt   = 7'(e_vb) * 7'd7;
    acc_or  = e_accum | ({{(WORD_W-7){1'b0}}, data_byte[6:0]} << shamt);
    vb_inc  = e_vb + VB_W'(1);
    ref_new = e_first ? acc_or : (e_ref + unzigzag(acc_or));
    fail    = 1'b0;

    phase_next          = phase;
    varint_accum_next   = varint_accum;
    varint_bytes_next   = varint_bytes;
    bytes_left_next     = bytes_left;
    chunks_left_next    = chunks_left;
    prev_time_next      = prev_time;
    prev_max_next       = prev_max;
    prev_ref_next       = prev_ref;
    is_first_chunk_next = is_first_chunk;

    res_valid = 1'b0;
    res       = '0;

    if (fire) begin
      phase_next          = e_phase;
      varint_accum_next   = e_accum;
      varint_bytes_next   = e_vb;
      bytes_left_next     = e_left;
      chunks_left_next    = e_chunks;
      prev_time_next      = e_time;
      prev_max_next       = e_max;
      prev_ref_next       = e_ref;
      is_first_chunk_next = e_first;

      if (e_phase != PH_IDLE) begin
        if (e_phase != PH_LEN && e_left == '0) begin
          fail = 1'b1;
        end else begin
          // the length varint does not count against the length
          if (e_phase != PH_LEN) begin
            bytes_left_next = e_left - WORD_W'(1);
          end
          if (e_vb >= VB_W'(MAX_VARINT_BYTES)) begin
            fail = 1'b1;
          end else if (data_byte[7]) begin
            if (vb_inc >= VB_W'(MAX_VARINT_BYTES)) begin
              fail = 1'b1;
            end else begin
              varint_accum_next = acc_or;
              varint_bytes_next = vb_inc;
            end
          end else begin
            varint_accum_next = '0;
            varint_bytes_next = '0;
            unique case (e_phase)
              PH_LEN: begin
                bytes_left_next = acc_or;
                phase_next      = PH_COUNT;
              end
              PH_COUNT: begin
                if (acc_or == '0) begin
                  phase_next = PH_IDLE;
                  res_valid  = 1'b1;
                  res.status = ST_EMPTY;
                end else begin
                  chunks_left_next = acc_or;
                  phase_next       = PH_TIME;
                end
              end
              PH_TIME: begin
                // later chunks: gap counted from previous max time
                prev_time_next = e_first ? unzigzag(acc_or) : (e_max + acc_or);
                phase_next     = PH_SPAN;
              end
              PH_SPAN: begin
                prev_max_next = e_time + acc_or;
                phase_next    = PH_REF;
              end
              PH_REF: begin
                prev_ref_next       = ref_new;
                is_first_chunk_next = 1'b0;
                chunks_left_next    = e_chunks - WORD_W'(1);
                phase_next          = (e_chunks == WORD_W'(1)) ? PH_IDLE : PH_TIME;
                res_valid           = 1'b1;
                res.status          = ST_META;
                res.chunk_ref       = ref_new;
                res.min_time        = e_time;
                res.max_time        = e_max;
                res.last_chunk      = (e_chunks == WORD_W'(1));
              end
              default: begin
                phase_next = e_phase;
              end
            endcase
          end
        end
      end

      if (fail) begin
        phase_next        = PH_IDLE;
        varint_accum_next = '0;
        varint_bytes_next = '0;
        res_valid         = 1'b1;
        res               = '0;
        res.status        = ST_ERROR;
      end
    end
  end

`ifndef SYNTHESIS
  a_last_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (fire && res_valid && res.status == ST_META && res.last_chunk) |=> (phase == PH_IDLE))
    else $error("parser not idle after last chunk");

  a_error_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (fire && res_valid && res.status == ST_ERROR) |=>
      (phase == PH_IDLE && varint_bytes == '0))
    else $error("parser not idle after decode error");

  a_chunks_pending: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_TIME || phase == PH_SPAN || phase == PH_REF) |-> (chunks_left != '0))
    else $error("chunk phase with no chunks left");

  a_no_result_idle: assert property (@(posedge clk) disable iff (rst)
    (fire && !entry_start && phase == PH_IDLE) |-> !res_valid)
    else $error("result produced while idle");
`endif

endmodule

// ----- hw/rtl/cmvd_out_reg.sv -----
// ----------------------------------------------------------------------------
// cmvd_out_reg
// result register: holds one result word until the receiver takes it
// ----------------------------------------------------------------------------
module cmvd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  cmvd_pkg::result_t res,
  input  logic              out_stall,
  output logic              ready,
  output logic              out_valid,
  output cmvd_pkg::result_t held
);
  import cmvd_pkg::*;

  assign ready = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      held <= res;
    end
  end

endmodule

// ----- hw/rtl/chunk_meta_varint_delta_decoder_top.sv -----
// ----------------------------------------------------------------------------
// chunk_meta_varint_delta_decoder_top
// decodes the chunk metadata of one series entry from a byte stream
// ----------------------------------------------------------------------------
// input channel: one byte word per accepted cycle (in_valid high, in_stall
// low), entry_start marks the first byte of a new entry and clears the
// parser. the entry is a LEB128 length, a chunk count, then time, span and
// reference varints per chunk.
// output channel: status, chunk_ref, min_time, max_time and last_chunk are
// taken when out_valid is high and out_stall is low. status gives chunk
// meta, empty series or decode error; only chunk meta carries nonzero fields.
// throughput: one byte per cycle while the result register is not stalled; the parser is a single
// registered pass between the input register and the result register.
// path: a byte passes the input register and the parser, and its result is
// loaded into the result register, which drives out_valid. only a byte that
// ends a zero count or a reference varint, or fails, gives a result word.
// reset: rst (synchronous) clears the parser to wait for a length and
// empties both registers. a stalled result holds; the input register takes
// at most one more byte, then in_stall stays high until the result is taken.
// ----------------------------------------------------------------------------
module chunk_meta_varint_delta_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        entry_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [63:0] chunk_ref,
  output logic signed [63:0] min_time,
  output logic signed [63:0] max_time,
  output logic        last_chunk
);
  import cmvd_pkg::*;

  logic       down_ready;
  logic       held_valid;
  logic [7:0] held_byte;
  logic       held_start;
  logic       fire;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  cmvd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .data_byte  (data_byte),
    .entry_start(entry_start),
    .down_ready (down_ready),
    .in_stall   (in_stall),
    .held_valid (held_valid),
    .held_byte  (held_byte),
    .held_start (held_start)
  );

  assign fire = held_valid & down_ready;

  cmvd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .data_byte  (held_byte),
    .entry_start(held_start),
    .res_valid  (res_valid),
    .res        (res)
  );

  cmvd_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (fire & res_valid),
    .res      (res),
    .out_stall(out_stall),
    .ready    (down_ready),
    .out_valid(out_valid),
    .held     (out_res)
  );

  assign status     = out_res.status;
  assign chunk_ref  = out_res.chunk_ref;
  assign min_time   = out_res.min_time;
  assign max_time   = out_res.max_time;
  assign last_chunk = out_res.last_chunk;

endmodule

// ----- tb/chunk_meta_varint_delta_decoder_checker.sv -----
// ----------------------------------------------------------------------------
// chunk_meta_varint_delta_decoder_checker
// watches both channels, decodes each accepted byte word in its own parser
// and compares every result word with the oldest predicted one
// ----------------------------------------------------------------------------
module chunk_meta_varint_delta_decoder_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               entry_start,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         status,
  input  logic [63:0]        chunk_ref,
  input  logic signed [63:0] min_time,
  input  logic signed [63:0] max_time,
  input  logic               last_chunk,
  output int                 mismatch_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import cmvd_pkg::*;

  phase_t      ph;
  logic [63:0] accum;
  int          nbytes;
  logic [63:0] bytes_left;
  logic [63:0] chunks_left;
  logic [63:0] cur_time;
  logic [63:0] cur_span;
  logic [63:0] cur_ref;
  logic        first_chunk;

  result_t     expected_meta[$];
  result_t     want;
  int          mismatches = 0;

  task automatic clear_entry();
    ph          = PH_LEN;
    accum       = '0;
    nbytes      = 0;
    bytes_left  = '0;
    chunks_left = '0;
    cur_time    = '0;
    cur_span    = '0;
    cur_ref     = '0;
    first_chunk = 1'b1;
  endtask

  task automatic push_word(input status_t st, input logic [63:0] r,
                           input logic [63:0] lo, input logic [63:0] hi,
                           input logic last);
    result_t w;
    w.status     = st;
    w.chunk_ref  = r;
    w.min_time   = lo;
    w.max_time   = hi;
    w.last_chunk = last;
    expected_meta.insert(expected_meta.size(), w);
  endtask

  task automatic decode_error();
    ph     = PH_IDLE;
    accum  = '0;
    nbytes = 0;
    push_word(ST_ERROR, '0, '0, '0, 1'b0);
  endtask

  function automatic logic [63:0] unzigzag(input logic [63:0] u);
    return (u >> 1) ^ {64{u[0]}};
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic start);
    logic [63:0] v;
    if (start)
      clear_entry();
    if (ph == PH_IDLE)
      return;
    // the length varint is not counted against the length
    if (ph != PH_LEN) begin
      if (bytes_left == 64'd0) begin
        decode_error();
        return;
      end
      bytes_left = bytes_left - 64'd1;
    end
    if (nbytes >= MAX_VARINT_BYTES) begin
      decode_error();
      return;
    end
    // bits of a tenth byte above bit 63 fall off here
    accum = accum | ({57'd0, b[6:0]} << (7 * nbytes));
    nbytes++;
    if (b[7]) begin
      if (nbytes >= MAX_VARINT_BYTES)
        decode_error();
      return;
    end
    v      = accum;
    accum  = '0;
    nbytes = 0;
    case (ph)
      PH_LEN: begin
        bytes_left = v;
        ph = PH_COUNT;
      end
      PH_COUNT: begin
        if (v == 64'd0) begin
          ph = PH_IDLE;
          push_word(ST_EMPTY, '0, '0, '0, 1'b0);
        end else begin
          chunks_left = v;
          ph = PH_TIME;
        end
      end
      PH_TIME: begin
        // later chunks carry the gap after the previous max time
        cur_time = first_chunk ? unzigzag(v) : cur_time + v + cur_span;
        ph = PH_SPAN;
      end
      PH_SPAN: begin
        cur_span = v;
        ph = PH_REF;
      end
      default: begin
        cur_ref     = first_chunk ? v : cur_ref + unzigzag(v);
        first_chunk = 1'b0;
        chunks_left = chunks_left - 64'd1;
        ph = (chunks_left == 64'd0) ? PH_IDLE : PH_TIME;
        push_word(ST_META, cur_ref, cur_time, cur_time + cur_span, chunks_left == 64'd0);
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_entry();
      expected_meta.delete();
    end else begin
      if (in_valid && !in_stall)
        decode_byte(data_byte, entry_start);
      if (out_valid && !out_stall) begin
        if (expected_meta.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected word: status %0d ref %h min %h max %h last %0d",
                     $realtime, status, chunk_ref, min_time, max_time, last_chunk);
        end else begin
          want = expected_meta.pop_front();
          if (status !== want.status || chunk_ref !== want.chunk_ref ||
              min_time !== want.min_time || max_time !== want.max_time ||
              last_chunk !== want.last_chunk) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: word differs: expected status %0d ref %h min %h max %h last %0d",
                       $realtime, want.status, want.chunk_ref, want.min_time,
                       want.max_time, want.last_chunk);
              $display("%0t:               got      status %0d ref %h min %h max %h last %0d",
                       $realtime, status, chunk_ref, min_time, max_time, last_chunk);
            end
          end
        end
      end
    end
    mismatch_count <= mismatches;
    pending        <= expected_meta.size();
  end

endmodule

// ----- tb/chunk_meta_varint_delta_decoder_top_test.sv -----
// ----------------------------------------------------------------------------
// chunk_meta_varint_delta_decoder_top_test
// feeds series entries byte by byte (good ones, short lengths, overlong
// varints, cut entries and noise) with bursty input and a stalling output,
// and leaves prediction and comparison to the checker beside the block
// ----------------------------------------------------------------------------
module chunk_meta_varint_delta_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cmvd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int END_WAIT       = 8;
  localparam int RANDOM_WORDS   = 450;

  typedef enum {EK_GOOD, EK_SHORT, EK_LONG_VARINT, EK_CUT, EK_NOISE} entry_kind_t;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               in_valid    = 1'b0;
  logic [7:0]         data_byte   = 8'd0;
  logic               entry_start = 1'b0;
  logic               out_stall   = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [1:0]         status;
  logic [63:0]        chunk_ref;
  logic signed [63:0] min_time;
  logic signed [63:0] max_time;
  logic               last_chunk;
  int                 mismatch_count;
  int                 pending;

  int                 burst_left = 0;
  bit                 steady     = 1'b0;
  int                 sent       = 0;
  int                 idle_cycles = 0;
  int                 run_left   = 0;
  int                 quiet_left = 0;
  bit                 quiet      = 1'b0;
  logic [7:0]         body_q[$];
  logic [7:0]         len_q[$];

  chunk_meta_varint_delta_decoder_top uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .entry_start (entry_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .chunk_ref   (chunk_ref),
    .min_time    (min_time),
    .max_time    (max_time),
    .last_chunk  (last_chunk)
  );

  chunk_meta_varint_delta_decoder_checker meta_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .entry_start    (entry_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .chunk_ref      (chunk_ref),
    .min_time       (min_time),
    .max_time       (max_time),
    .last_chunk     (last_chunk),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: runs of stall or no stall, with quiet stretches in between
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      run_left   <= 0;
      quiet_left <= 0;
    end else begin
      if (quiet_left == 0) begin
        quiet      <= ($urandom_range(0, 3) == 0);
        quiet_left <= $urandom_range(50, 300);
      end else begin
        quiet_left <= quiet_left - 1;
      end
      if (run_left == 0) begin
        run_left  <= $urandom_range(1, 20);
        out_stall <= quiet ? 1'b0 : ($urandom_range(0, 2) == 0);
      end else begin
        run_left <= run_left - 1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("chunk_meta_varint_delta_decoder_top: mismatch");
      $finish;
    end
  end

  task automatic send_word(input logic [7:0] b, input logic s);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    data_byte   <= b;
    entry_start <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_value();
    logic [63:0] r;
    case ($urandom_range(0, 9))
      4:       r = 64'($urandom_range(128, 20000));
      5:       r = {$urandom, $urandom} >> $urandom_range(0, 63);
      6:       r = {$urandom, $urandom};
      7: begin
        case ($urandom_range(0, 5))
          0:       r = 64'd0;
          1:       r = 64'hffff_ffff_ffff_ffff;
          2:       r = 64'hffff_ffff_ffff_fffe;
          3:       r = 64'h8000_0000_0000_0000;
          4:       r = 64'h7fff_ffff_ffff_ffff;
          default: r = 64'd128;
        endcase
      end
      default: r = 64'($urandom_range(0, 127));
    endcase
    return r;
  endfunction

  // LEB128 encode; odd_top fills the dead upper bits of a tenth byte
  task automatic put_varint(input logic [63:0] v, input bit to_len, input bit odd_top);
    logic [7:0] b;
    int         n;
    n = 0;
    do begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      n++;
      if (v != 0)
        b[7] = 1'b1;
      else if (n == 10 && odd_top)
        b[6:1] = 6'($urandom_range(0, 63));
      if (to_len)
        len_q.insert(len_q.size(), b);
      else
        body_q.insert(body_q.size(), b);
    end while (v != 0);
  endtask

  task automatic run_entry(input entry_kind_t kind);
    int          chunks;
    int          cut;
    int          i;
    int          extra;
    int          n;
    logic [63:0] count_val;
    logic [63:0] stated_len;
    body_q.delete();
    len_q.delete();
    if (kind == EK_NOISE) begin
      n = $urandom_range(1, 6);
      repeat (n)
        send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      sent += n;
      return;
    end
    if (kind == EK_LONG_VARINT && $urandom_range(0, 3) == 0) begin
      // length varint that never ends
      n = $urandom_range(9, 11);
      send_word(8'h80 | 8'($urandom_range(0, 127)), 1'b1);
      repeat (n)
        send_word(8'h80 | 8'($urandom_range(0, 127)), 1'b0);
      sent += n + 1;
      return;
    end
    case ($urandom_range(0, 9))
      0:       chunks = 0;
      1:       chunks = $urandom_range(5, 10);
      default: chunks = $urandom_range(1, 4);
    endcase
    count_val = 64'(chunks);
    // count claims more chunks than the entry holds
    if (kind == EK_SHORT && $urandom_range(0, 2) == 0)
      count_val = 64'(chunks) + 64'($urandom_range(1, 3));
    put_varint(count_val, 1'b0, 1'b0);
    repeat (chunks * 3)
      put_varint(pick_value(), 1'b0, 1'($urandom_range(0, 1)));
    stated_len = 64'(body_q.size());
    cut = body_q.size();
    case (kind)
      EK_GOOD: begin
        if ($urandom_range(0, 9) == 0) begin
          stated_len = ($urandom_range(0, 1) == 0) ? 64'hffff_ffff_ffff_ffff
                                                   : stated_len + {$urandom, $urandom} / 2;
        end else if ($urandom_range(0, 3) == 0) begin
          extra = $urandom_range(1, 4);
          repeat (extra) body_q.insert(body_q.size(), 8'($urandom_range(0, 255)));
          stated_len = stated_len + 64'(extra);
          cut = cut + extra;
        end
      end
      EK_SHORT: begin
        if (count_val == 64'(chunks))
          stated_len = stated_len -
                       64'($urandom_range(1, (body_q.size() < 3) ? body_q.size() : 3));
      end
      EK_CUT:
        cut = $urandom_range(0, body_q.size() - 1);
      default: begin
        cut = $urandom_range(0, body_q.size());
        stated_len = stated_len + 64'd12;
      end
    endcase
    put_varint(stated_len, 1'b1, 1'b0);
    for (i = 0; i < len_q.size(); i++)
      send_word(len_q[i], i == 0);
    for (i = 0; i < cut; i++)
      send_word(body_q[i], 1'b0);
    sent += len_q.size() + cut;
    if (kind == EK_LONG_VARINT) begin
      n = $urandom_range(10, 11);
      repeat (n)
        send_word(8'h80 | 8'($urandom_range(0, 127)), 1'b0);
      sent += n;
    end
    // trailing bytes, ignored once the entry is done
    if (kind != EK_CUT && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n)
        send_word(8'($urandom_range(0, 255)), 1'b0);
      sent += n;
    end
  endtask

  initial begin
    int k;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // entry straight after reset with no start mark, first time of -1
    send_word(8'h04, 1'b0);
    send_word(8'h01, 1'b0);
    send_word(8'h01, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b0);
    // empty series, then a trailing word that is ignored
    send_word(8'h01, 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'haa, 1'b0);
    // zero length, so the count word reads past the end
    send_word(8'h00, 1'b1);
    send_word(8'h01, 1'b0);
    // length varint running to ten words, then an ignored word
    send_word(8'hff, 1'b1);
    repeat (9) send_word(8'hff, 1'b0);
    send_word(8'h01, 1'b0);

    while (sent < RANDOM_WORDS) begin
      steady = ($urandom_range(0, 3) == 0);
      k = $urandom_range(0, 99);
      if (k < 60)
        run_entry(EK_GOOD);
      else if (k < 72)
        run_entry(EK_SHORT);
      else if (k < 80)
        run_entry(EK_LONG_VARINT);
      else if (k < 92)
        run_entry(EK_CUT);
      else
        run_entry(EK_NOISE);
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (END_WAIT) @(posedge clk);
    if (mismatch_count == 0 && pending == 0)
      $display("chunk_meta_varint_delta_decoder_top: match");
    else
      $display("chunk_meta_varint_delta_decoder_top: mismatch");
    $finish;
  end

endmodule
